@@ rtl/rot_pkg.sv @@
package rot_pkg;

	localparam int unsigned STORE_PIXELS   = 65536;
	localparam int unsigned MAX_DIM        = 4096;
	localparam int unsigned MAX_COMPONENTS = 4;
	localparam int unsigned OUTQ_DEPTH     = 8;

	localparam int unsigned DIM_W    = 13;
	localparam int unsigned ORI_W    = 4;
	localparam int unsigned COMP_W   = 3;
	localparam int unsigned PIX_W    = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	typedef enum logic [1:0] {
		REG_ORIENTATION  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_COMPONENTS   = 2'd3
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_INCOMPLETE = 3'd2,
		ST_NO_MORE    = 3'd3,
		ST_OVERFLOW   = 3'd4
	} status_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [ORI_W-1:0] ORI_IDENTITY   = 4'd1;
	localparam logic [ORI_W-1:0] ORI_MIRROR_H   = 4'd2;
	localparam logic [ORI_W-1:0] ORI_ROT_180    = 4'd3;
	localparam logic [ORI_W-1:0] ORI_MIRROR_V   = 4'd4;
	localparam logic [ORI_W-1:0] ORI_TRANSPOSE  = 4'd5;
	localparam logic [ORI_W-1:0] ORI_ROT_CW     = 4'd6;
	localparam logic [ORI_W-1:0] ORI_TRANSVERSE = 4'd7;
	localparam logic [ORI_W-1:0] ORI_ROT_CCW    = 4'd8;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		status_t          status;
		logic             last_in_row;
		logic             last_of_image;
	} result_t;

endpackage

@@ rtl/raster_orientation_transform.sv @@
// Frame store that turns or mirrors an image into upright raster order.
// Input channel (in_valid/in_ready, op, pixel_data): op write stores the next
// pixel of the stored image in raster order; op read requests the next pixel
// of the upright image. A write that succeeds gives no result; every read and
// every failed write gives exactly one result on the output channel
// (out_valid/out_ready, pixel_out, status, last_in_row, last_of_image).
// The user must write registers over APB only while the block is idle; the
// block does not enforce this. One request per cycle is taken while in_ready
// is high; each passes decision, source coordinates, row multiply and the
// registered read of the frame store. Results wait in an eight-entry queue;
// in_ready drops while eight results are outstanding, so a stalled receiver
// holds the input side back without losing anything. in_ready is also low for
// one cycle after each register write and after reset, while the geometry
// figures are recomputed. Reset restores the register defaults and restarts
// loading and reading; the frame store is not cleared and needs no clearing
// pass, since a read is only answered once the whole image has been written.
module raster_orientation_transform #(
	parameter int unsigned STORE_PIXELS = rot_pkg::STORE_PIXELS,
	parameter int unsigned MAX_DIM      = rot_pkg::MAX_DIM
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rot_pkg::PADDR_W-1:0]  paddr,
	input  logic [rot_pkg::PDATA_W-1:0]  pwdata,
	output logic [rot_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [rot_pkg::PIX_W-1:0]    pixel_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rot_pkg::PIX_W-1:0]    pixel_out,
	output logic [rot_pkg::STATUS_W-1:0] status,
	output logic                         last_in_row,
	output logic                         last_of_image
);

	localparam int unsigned DIM_W  = rot_pkg::DIM_W;
	localparam int unsigned PIX_W  = rot_pkg::PIX_W;
	localparam int unsigned PROD_W = 2 * DIM_W;
	localparam int unsigned AW     = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
	localparam int unsigned PL_W   = $clog2(STORE_PIXELS + 1);
	localparam int unsigned COL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned LINE_W = $clog2(MAX_DIM + 1);
	localparam int unsigned CMP_W  = (LINE_W > DIM_W) ? LINE_W : DIM_W;
	localparam int unsigned PEND_W = $clog2(rot_pkg::OUTQ_DEPTH + 1);

	typedef struct packed {
		rot_pkg::status_t status;
		logic             rd_ok;
		logic             lr;
		logic             li;
	} meta_t;

	// Configuration registers.
	logic [rot_pkg::ORI_W-1:0]  orientation_q;
	logic [DIM_W-1:0]           image_width_q;
	logic [DIM_W-1:0]           image_height_q;
	logic [rot_pkg::COMP_W-1:0] components_q;
	logic                       cfg_wr;
	logic                       cfg_settle_q;
	rot_pkg::reg_idx_t          reg_idx;

	// Geometry figures, recomputed every cycle from the registers.
	logic [PROD_W-1:0] area;
	logic              geo_ok_d;
	logic              swap_d;
	logic [PIX_W-1:0]  mask_d;
	logic              geo_ok_q;
	logic [PL_W-1:0]   total_q;
	logic [DIM_W-1:0]  ow_q;
	logic [DIM_W-1:0]  oh_q;
	logic [PIX_W-1:0]  mask_q;

	// Progress counters.
	logic [PL_W-1:0]   pl_q;
	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;
	logic [PL_W-1:0]   pl_d;
	logic [COL_W-1:0]  col_d;
	logic [LINE_W-1:0] line_d;
	logic [PEND_W-1:0] pending_q;

	logic              accept;
	logic              pop;
	logic              gives_result;
	logic              wr_en;
	meta_t             res_meta;
	logic              col_wrap;
	logic [COL_W-1:0]  col_a;
	logic [LINE_W-1:0] line_a;
	logic              exhausted;
	logic              incomplete;
	logic              last_col;
	logic              last_line;

	// Pipeline.
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	meta_t             meta_s1, meta_s2, meta_s3, meta_s4;
	logic [COL_W-1:0]  x_s1;
	logic [COL_W-1:0]  y_s1;
	logic [DIM_W-1:0]  sx_s2;
	logic [DIM_W-1:0]  sy_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [DIM_W-1:0]  sx_s3;
	logic [DIM_W-1:0]  sx_d;
	logic [DIM_W-1:0]  sy_d;
	logic [DIM_W-1:0]  xd;
	logic [DIM_W-1:0]  yd;
	logic [AW-1:0]     raddr;
	logic [PIX_W-1:0]  ram_rdata;
	rot_pkg::result_t  push_data;
	rot_pkg::result_t  out_data;

	// ---------------------------------------------------------------- registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = rot_pkg::reg_idx_t'(paddr[rot_pkg::PADDR_W-1:2]);

	always_comb begin
		unique case (reg_idx)
			rot_pkg::REG_ORIENTATION:  prdata = rot_pkg::PDATA_W'(orientation_q);
			rot_pkg::REG_IMAGE_WIDTH:  prdata = rot_pkg::PDATA_W'(image_width_q);
			rot_pkg::REG_IMAGE_HEIGHT: prdata = rot_pkg::PDATA_W'(image_height_q);
			rot_pkg::REG_COMPONENTS:   prdata = rot_pkg::PDATA_W'(components_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q  <= rot_pkg::ORI_IDENTITY;
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
			components_q   <= rot_pkg::COMP_W'(1);
			cfg_settle_q   <= 1'b1;
		end else begin
			cfg_settle_q <= cfg_wr;
			if (cfg_wr) begin
				unique case (reg_idx)
					rot_pkg::REG_ORIENTATION:  orientation_q  <= pwdata[rot_pkg::ORI_W-1:0];
					rot_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[DIM_W-1:0];
					rot_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
					rot_pkg::REG_COMPONENTS:   components_q   <= pwdata[rot_pkg::COMP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- geometry
	always_comb begin
		area     = PROD_W'(image_width_q) * PROD_W'(image_height_q);
		geo_ok_d = (image_width_q != '0) && (32'(image_width_q) <= MAX_DIM)
			&& (image_height_q != '0) && (32'(image_height_q) <= MAX_DIM)
			&& (components_q != '0)
			&& (32'(components_q) <= rot_pkg::MAX_COMPONENTS)
			&& (32'(area) <= STORE_PIXELS);
		swap_d = (orientation_q >= rot_pkg::ORI_TRANSPOSE)
			&& (orientation_q <= rot_pkg::ORI_ROT_CCW);
		case (components_q)
			3'd0:    mask_d = 32'h0000_0000;
			3'd1:    mask_d = 32'h0000_00FF;
			3'd2:    mask_d = 32'h0000_FFFF;
			3'd3:    mask_d = 32'h00FF_FFFF;
			default: mask_d = 32'hFFFF_FFFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_ok_q <= 1'b0;
		end else begin
			geo_ok_q <= geo_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		total_q <= PL_W'(area);
		ow_q    <= swap_d ? image_height_q : image_width_q;
		oh_q    <= swap_d ? image_width_q : image_height_q;
		mask_q  <= mask_d;
	end

	// ---------------------------------------------------------------- decision
	assign pop      = out_valid && out_ready;
	assign in_ready = !cfg_settle_q && (pending_q < PEND_W'(rot_pkg::OUTQ_DEPTH));
	assign accept   = in_valid && in_ready;

	always_comb begin
		// A column left beyond the width (after a geometry change) moves to the next line.
		col_wrap   = CMP_W'(col_q) >= CMP_W'(ow_q);
		col_a      = col_wrap ? '0 : col_q;
		line_a     = col_wrap ? line_q + 1'b1 : line_q;
		exhausted  = CMP_W'(line_a) >= CMP_W'(oh_q);
		incomplete = pl_q < total_q;
		last_col   = (CMP_W'(col_a) + 1'b1) == CMP_W'(ow_q);
		last_line  = (CMP_W'(line_a) + 1'b1) == CMP_W'(oh_q);

		gives_result    = 1'b0;
		wr_en           = 1'b0;
		pl_d            = pl_q;
		col_d           = col_q;
		line_d          = line_q;
		res_meta.status = rot_pkg::ST_OK;
		res_meta.rd_ok  = 1'b0;
		res_meta.lr     = 1'b0;
		res_meta.li     = 1'b0;

		if (!geo_ok_q) begin
			gives_result    = 1'b1;
			res_meta.status = rot_pkg::ST_TOO_LARGE;
		end else if (op == rot_pkg::OP_WRITE) begin
			if (incomplete) begin
				wr_en = 1'b1;
				pl_d  = pl_q + 1'b1;
			end else begin
				gives_result    = 1'b1;
				res_meta.status = rot_pkg::ST_OVERFLOW;
			end
		end else begin
			gives_result = 1'b1;
			col_d        = col_a;
			line_d       = line_a;
			if (exhausted) begin
				res_meta.status = rot_pkg::ST_NO_MORE;
			end else if (incomplete) begin
				res_meta.status = rot_pkg::ST_INCOMPLETE;
			end else begin
				res_meta.rd_ok = 1'b1;
				res_meta.lr    = last_col;
				res_meta.li    = last_col && last_line;
				col_d          = last_col ? '0 : col_a + 1'b1;
				line_d         = last_col ? line_a + 1'b1 : line_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q      <= '0;
			col_q     <= '0;
			line_q    <= '0;
			pending_q <= '0;
		end else begin
			if (accept) begin
				pl_q   <= pl_d;
				col_q  <= col_d;
				line_q <= line_d;
			end
			if ((accept && gives_result) && !pop) begin
				pending_q <= pending_q + 1'b1;
			end else if (!(accept && gives_result) && pop) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- pipeline
	always_comb begin
		xd = DIM_W'(x_s1);
		yd = DIM_W'(y_s1);
		unique case (orientation_q)
			rot_pkg::ORI_MIRROR_H: begin
				sx_d = image_width_q - 1'b1 - xd;
				sy_d = yd;
			end
			rot_pkg::ORI_ROT_180: begin
				sx_d = image_width_q - 1'b1 - xd;
				sy_d = image_height_q - 1'b1 - yd;
			end
			rot_pkg::ORI_MIRROR_V: begin
				sx_d = xd;
				sy_d = image_height_q - 1'b1 - yd;
			end
			rot_pkg::ORI_TRANSPOSE: begin
				sx_d = yd;
				sy_d = xd;
			end
			rot_pkg::ORI_ROT_CW: begin
				sx_d = yd;
				sy_d = image_height_q - 1'b1 - xd;
			end
			rot_pkg::ORI_TRANSVERSE: begin
				sx_d = image_width_q - 1'b1 - yd;
				sy_d = image_height_q - 1'b1 - xd;
			end
			rot_pkg::ORI_ROT_CCW: begin
				sx_d = image_width_q - 1'b1 - yd;
				sy_d = xd;
			end
			default: begin
				sx_d = xd;
				sy_d = yd;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept && gives_result;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= res_meta;
		x_s1    <= col_a;
		y_s1    <= line_a[COL_W-1:0];
		meta_s2 <= meta_s1;
		sx_s2   <= sx_d;
		sy_s2   <= sy_d;
		meta_s3 <= meta_s2;
		prod_s3 <= PROD_W'(sy_s2) * PROD_W'(image_width_q);
		sx_s3   <= sx_s2;
		meta_s4 <= meta_s3;
	end

	assign raddr = AW'(prod_s3 + PROD_W'(sx_s3));

	rot_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (pl_q[AW-1:0]),
		.wdata (pixel_data & mask_q),
		.re    (valid_s3 && meta_s3.rd_ok),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		push_data.pixel         = meta_s4.rd_ok ? (ram_rdata & mask_q) : '0;
		push_data.status        = meta_s4.status;
		push_data.last_in_row   = meta_s4.lr;
		push_data.last_of_image = meta_s4.li;
	end

	rot_outq #(
		.DEPTH (rot_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s4),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign pixel_out     = out_data.pixel;
	assign status        = out_data.status;
	assign last_in_row   = out_data.last_in_row;
	assign last_of_image = out_data.last_of_image;

endmodule

@@ rtl/rot_ram.sv @@
module rot_ram #(
	parameter int unsigned WIDTH = rot_pkg::PIX_W,
	parameter int unsigned DEPTH = rot_pkg::STORE_PIXELS
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rot_outq.sv @@
module rot_outq #(
	parameter int unsigned DEPTH = rot_pkg::OUTQ_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rot_pkg::result_t  push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rot_pkg::result_t  out_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rot_pkg::result_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/rot_checker.sv @@
module rot_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rot_pkg::PIX_W-1:0]    pixel_out,
	input logic [rot_pkg::STATUS_W-1:0] status,
	input logic                         last_in_row,
	input logic                         last_of_image
);

	// A result held back by the receiver must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(status)
			&& $stable(last_in_row) && $stable(last_of_image))
		else $error("result changed while stalled");

	// Error results carry no pixel and no row marks.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rot_pkg::ST_OK)
			|-> (pixel_out == '0) && !last_in_row && !last_of_image)
		else $error("error result carries pixel or row marks");

	// The final pixel of the image always closes a row.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_image |-> last_in_row && (status == rot_pkg::ST_OK))
		else $error("last_of_image without last_in_row");

	// Geometry is recomputed after a register write before the next request.
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !in_ready)
		else $error("request accepted before geometry settled");

endmodule

bind raster_orientation_transform rot_checker u_rot_checker (.*);
